// File: rtl/lfn_pkg.sv
// lattice fiber neighbor package: field widths, status codes and payload structs
// no dependencies; imported by the interface users and the top level

package lfn_pkg;

   localparam int EDGE_W      = 15;
   localparam int SLOT_W      = 3;
   localparam int RECIP_SHIFT = 24;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic [EDGE_W-1:0] edge_index;
      logic [SLOT_W-1:0] neighbor_slot;
   } req_payload_type;

   typedef struct packed {
      logic [EDGE_W-1:0] neighbor_edge;
      logic              status;
   } rsp_payload_type;

endpackage

// File: rtl/lfn_stream_if.sv
// valid/ready stream interface with a typed payload
// no dependencies; the payload type is given where it is instantiated

interface lfn_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/lattice_fiber_neighbor_top.sv
// lattice fiber neighbor lookup, top level
// depends on lfn_pkg and lfn_stream_if

// Returns the index of one of eight neighboring fibers of a fiber in a layered
// lattice of NODES_PER_ROW x NODES_PER_COLUMN nodes, folding back at the borders.
// Indices at or beyond the fiber count give status 1 and a zero neighbor index.
// One transaction is taken per clock cycle unless a stall of the result side backs up
// to the input; a result is held at the output while the result side stalls. The divide
// by the row stride is split up: after the input register it is done as a
// reciprocal multiply, a back multiply and a one-step correction, each in a stage
// of its own, and the neighbor select then feeds the output register.

module lattice_fiber_neighbor_top
   import lfn_pkg::*;
#(
   parameter int NODES_PER_ROW    = 64,
   parameter int NODES_PER_COLUMN = 128
) (
   input logic           clock,
   input logic           reset,
   lfn_stream_if.sink    req_chan,
   lfn_stream_if.source  rsp_chan
);

   localparam int ROW_STRIDE  = 3 * NODES_PER_ROW - 1;
   localparam int XZ_SPAN     = 2 * NODES_PER_ROW - 1;
   localparam int FIBER_COUNT = 3 * NODES_PER_ROW * NODES_PER_COLUMN
                                - NODES_PER_ROW - NODES_PER_COLUMN;
   localparam int RECIP       = (1 << RECIP_SHIFT) / ROW_STRIDE;
   localparam int RC_W        = $clog2(RECIP + 1);
   localparam int QP_W        = EDGE_W + RC_W;
   localparam int P_W         = $clog2(ROW_STRIDE);
   localparam int X_W         = $clog2(NODES_PER_ROW);
   localparam int STAGES      = 5;

   typedef enum logic [1:0] {
      KIND_OUT   = 2'd0,
      KIND_RIGHT = 2'd1,
      KIND_UP    = 2'd2
   } fiber_kind_type;

   typedef enum logic [2:0] {
      FOLD_LEFT  = 3'd0,
      FOLD_RIGHT = 3'd1,
      FOLD_DOWN  = 3'd2,
      FOLD_UP    = 3'd3,
      FOLD_OUT   = 3'd4
   } fold_type;

   // pipeline control
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] go;

   // stage 0: input register
   logic [EDGE_W-1:0] e0_ff;
   logic [SLOT_W-1:0] s0_ff;

   // stage 1: reciprocal quotient estimate
   logic [QP_W-1:0]   quot_prod;
   logic [EDGE_W-1:0] quot1_in, quot1_ff;
   logic [EDGE_W-1:0] e1_ff;
   logic [SLOT_W-1:0] s1_ff;
   logic              err1_in, err1_ff;

   // stage 2: back multiply
   logic [EDGE_W-1:0] prod2_in, prod2_ff;
   logic [EDGE_W-1:0] quot2_ff;
   logic [EDGE_W-1:0] e2_ff;
   logic [SLOT_W-1:0] s2_ff;
   logic              err2_ff;

   // stage 3: corrected row and position
   logic [EDGE_W-1:0] rem;
   logic              over;
   logic [EDGE_W-1:0] y3_in, y3_ff;
   logic [P_W-1:0]    p3_in, p3_ff;
   logic [EDGE_W-1:0] base3_in, base3_ff;
   logic [SLOT_W-1:0] s3_ff;
   logic              err3_ff;

   // stage 4: neighbor select
   fiber_kind_type    kind;
   fiber_kind_type    tkind;
   fold_type          fold;
   logic [X_W-1:0]    x;
   logic [X_W-1:0]    xs;
   logic [X_W-1:0]    xt;
   logic              row_next;
   logic              row_add;
   logic              row_sub;
   logic [EDGE_W-1:0] col;
   logic [EDGE_W-1:0] row_term;
   logic [EDGE_W-1:0] sum;
   rsp_payload_type   rsp_in, rsp_ff;

   always_comb begin
      go[STAGES-1] = !vld_ff[STAGES-1] || rsp_chan.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         go[k] = !vld_ff[k] || go[k+1];
      end
      vld_in[0] = go[0] ? req_chan.valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = go[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1 logic
   always_comb begin
      quot_prod = {{RC_W{1'b0}}, e0_ff} * {{EDGE_W{1'b0}}, RC_W'(RECIP)};
      quot1_in  = EDGE_W'(quot_prod >> RECIP_SHIFT);
      err1_in   = 32'(e0_ff) >= 32'(FIBER_COUNT);
   end

   // stage 2 logic
   always_comb begin
      prod2_in = EDGE_W'(quot1_ff * EDGE_W'(ROW_STRIDE));
   end

   // stage 3 logic
   always_comb begin
      rem      = e2_ff - prod2_ff;
      over     = rem >= EDGE_W'(ROW_STRIDE);
      y3_in    = over ? quot2_ff + EDGE_W'(1) : quot2_ff;
      p3_in    = over ? P_W'(rem - EDGE_W'(ROW_STRIDE)) : P_W'(rem);
      base3_in = over ? prod2_ff + EDGE_W'(ROW_STRIDE) : prod2_ff;
   end

   // stage 4 logic
   always_comb begin
      kind     = KIND_OUT;
      x        = X_W'(p3_ff >> 1);
      xs       = x;
      row_next = 1'b0;
      fold     = FOLD_OUT;
      tkind    = KIND_OUT;
      xt       = xs;
      row_add  = 1'b0;
      row_sub  = 1'b0;

      if (p3_ff >= P_W'(XZ_SPAN)) begin
         kind = KIND_UP;
         x    = X_W'(p3_ff - P_W'(XZ_SPAN));
      end else if (p3_ff[0]) begin
         kind = KIND_RIGHT;
      end

      case (kind)
         KIND_UP: begin
            xs       = x;
            row_next = s3_ff[2];
            case (s3_ff[1:0])
               2'd0:    fold = FOLD_LEFT;
               2'd3:    fold = FOLD_RIGHT;
               default: fold = FOLD_OUT;
            endcase
         end
         KIND_RIGHT: begin
            xs = s3_ff[2] ? x + X_W'(1) : x;
            case (s3_ff[1:0])
               2'd0:    fold = FOLD_DOWN;
               2'd3:    fold = FOLD_UP;
               default: fold = FOLD_OUT;
            endcase
         end
         default: begin
            xs = x;
            case (s3_ff[2:1])
               2'd0:    fold = FOLD_LEFT;
               2'd1:    fold = FOLD_RIGHT;
               2'd2:    fold = FOLD_DOWN;
               default: fold = FOLD_UP;
            endcase
         end
      endcase

      case (fold)
         FOLD_LEFT: begin
            tkind   = KIND_RIGHT;
            xt      = (xs != '0) ? xs - X_W'(1) : xs;
            row_add = row_next;
         end
         FOLD_RIGHT: begin
            tkind   = KIND_RIGHT;
            xt      = (xs != X_W'(NODES_PER_ROW - 1)) ? xs : xs - X_W'(1);
            row_add = row_next;
         end
         FOLD_DOWN: begin
            tkind   = KIND_UP;
            xt      = xs;
            row_sub = (y3_ff != '0);
         end
         FOLD_UP: begin
            tkind   = KIND_UP;
            xt      = xs;
            row_sub = (y3_ff == EDGE_W'(NODES_PER_COLUMN - 1));
         end
         default: begin
            tkind   = KIND_OUT;
            xt      = xs;
            row_add = row_next;
         end
      endcase

      case (tkind)
         KIND_UP:    col = EDGE_W'(XZ_SPAN) + EDGE_W'(xt);
         KIND_RIGHT: col = EDGE_W'({xt, 1'b1});
         default:    col = EDGE_W'({xt, 1'b0});
      endcase

      if (row_add) begin
         row_term = EDGE_W'(ROW_STRIDE);
      end else if (row_sub) begin
         row_term = EDGE_W'(0) - EDGE_W'(ROW_STRIDE);
      end else begin
         row_term = '0;
      end

      sum = base3_ff + col + row_term;

      rsp_in.neighbor_edge = err3_ff ? '0 : sum;
      rsp_in.status        = err3_ff ? STATUS_RANGE : STATUS_OK;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (go[0]) begin
         e0_ff <= req_chan.payload.edge_index;
         s0_ff <= req_chan.payload.neighbor_slot;
      end
      if (go[1]) begin
         quot1_ff <= quot1_in;
         e1_ff    <= e0_ff;
         s1_ff    <= s0_ff;
         err1_ff  <= err1_in;
      end
      if (go[2]) begin
         prod2_ff <= prod2_in;
         quot2_ff <= quot1_ff;
         e2_ff    <= e1_ff;
         s2_ff    <= s1_ff;
         err2_ff  <= err1_ff;
      end
      if (go[3]) begin
         y3_ff    <= y3_in;
         p3_ff    <= p3_in;
         base3_ff <= base3_in;
         s3_ff    <= s2_ff;
         err3_ff  <= err2_ff;
      end
      if (go[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_chan.ready   = go[0];
   assign rsp_chan.valid   = vld_ff[STAGES-1];
   assign rsp_chan.payload = rsp_ff;

   // an empty output register never holds back a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("request stalled with empty output register");

   // corrected position always lies inside one row
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (32'(p3_ff) < 32'(ROW_STRIDE)))
      else $error("row position out of range after correction");

   // out of range transactions carry a zero neighbor index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.status == STATUS_RANGE)
         |-> (rsp_chan.payload.neighbor_edge == '0))
      else $error("nonzero neighbor index on range error");

endmodule

// File: verif/tb_top.sv
// testbench for lattice_fiber_neighbor_top: directed table, then random fiber lookups
// checked against a local neighbor predictor; needs lfn_pkg, lfn_stream_if and the top level

module tb_top;
   import lfn_pkg::*;

   localparam int NODES_PER_ROW    = 64;
   localparam int NODES_PER_COLUMN = 128;

   localparam int unsigned ROW_STRIDE  = 3 * NODES_PER_ROW - 1;
   localparam int unsigned CROSS_SPAN  = 2 * NODES_PER_ROW - 1;
   localparam int unsigned FIBER_COUNT = 3 * NODES_PER_ROW * NODES_PER_COLUMN
                                         - NODES_PER_ROW - NODES_PER_COLUMN;
   localparam int unsigned LAST_X      = NODES_PER_ROW - 1;
   localparam int unsigned LAST_Y      = NODES_PER_COLUMN - 1;

   localparam int RANDOM_ITEMS = 1600;
   localparam int IDLE_PCT     = 38;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic [SLOT_W-1:0] {
      SLOT_NEAR_LO, SLOT_NEAR_OUT_A, SLOT_NEAR_OUT_B, SLOT_NEAR_HI,
      SLOT_FAR_LO,  SLOT_FAR_OUT_A,  SLOT_FAR_OUT_B,  SLOT_FAR_HI
   } slot_code_type;

   typedef enum logic [1:0] {
      PAIR_LEFT, PAIR_RIGHT, PAIR_DOWN, PAIR_UP
   } pair_code_type;

   typedef struct packed {
      logic [EDGE_W-1:0] edge_index;
      slot_code_type     slot;
      logic              fixed;
      logic [EDGE_W-1:0] fixed_edge;
      logic              fixed_status;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;

   stim_row_type directed_table [DIRECTED_ROWS] = '{
      '{15'd0,     SLOT_NEAR_LO,    1'b1, 15'd1,     STATUS_OK},
      '{15'd0,     SLOT_FAR_HI,     1'b1, 15'd127,   STATUS_OK},
      '{15'd0,     SLOT_FAR_LO,     1'b1, 15'd127,   STATUS_OK},
      '{15'd24383, SLOT_NEAR_OUT_B, 1'b1, 15'd24382, STATUS_OK},
      '{15'd24383, SLOT_FAR_HI,     1'b1, 15'd24256, STATUS_OK},
      '{15'd24384, SLOT_NEAR_LO,    1'b1, 15'd0,     STATUS_RANGE},
      '{15'd32767, SLOT_FAR_HI,     1'b1, 15'd0,     STATUS_RANGE},
      '{15'd32767, SLOT_NEAR_LO,    1'b1, 15'd0,     STATUS_RANGE},
      '{15'd127,   SLOT_NEAR_LO,    1'b0, 15'd0,     STATUS_OK},
      '{15'd127,   SLOT_NEAR_OUT_A, 1'b0, 15'd0,     STATUS_OK},
      '{15'd127,   SLOT_FAR_LO,     1'b0, 15'd0,     STATUS_OK},
      '{15'd127,   SLOT_FAR_HI,     1'b0, 15'd0,     STATUS_OK},
      '{15'd190,   SLOT_NEAR_HI,    1'b0, 15'd0,     STATUS_OK},
      '{15'd190,   SLOT_FAR_OUT_B,  1'b0, 15'd0,     STATUS_OK},
      '{15'd1,     SLOT_NEAR_LO,    1'b0, 15'd0,     STATUS_OK},
      '{15'd1,     SLOT_NEAR_HI,    1'b0, 15'd0,     STATUS_OK},
      '{15'd1,     SLOT_FAR_OUT_A,  1'b0, 15'd0,     STATUS_OK},
      '{15'd125,   SLOT_FAR_HI,     1'b0, 15'd0,     STATUS_OK},
      '{15'd125,   SLOT_FAR_LO,     1'b0, 15'd0,     STATUS_OK},
      '{15'd24258, SLOT_NEAR_HI,    1'b0, 15'd0,     STATUS_OK},
      '{15'd24258, SLOT_FAR_HI,     1'b0, 15'd0,     STATUS_OK},
      '{15'd126,   SLOT_NEAR_OUT_B, 1'b0, 15'd0,     STATUS_OK},
      '{15'd24203, SLOT_FAR_OUT_A,  1'b0, 15'd0,     STATUS_OK},
      '{15'd24203, SLOT_FAR_HI,     1'b0, 15'd0,     STATUS_OK},
      '{15'd24256, SLOT_FAR_HI,     1'b0, 15'd0,     STATUS_OK}
   };

   int unsigned border_y [4] = '{0, 1, LAST_Y - 1, LAST_Y};
   int unsigned border_p [9] = '{0, 1, 2, CROSS_SPAN - 2, CROSS_SPAN - 1, CROSS_SPAN,
                                 CROSS_SPAN + 1, ROW_STRIDE - 2, ROW_STRIDE - 1};

   logic clock;
   logic reset;
   logic steady_run;
   int   fail_count = 0;

   rsp_payload_type pending_neighbors [$];

   lfn_stream_if #(.payload_type(req_payload_type)) req_if ();
   lfn_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   lattice_fiber_neighbor_top #(
      .NODES_PER_ROW    (NODES_PER_ROW),
      .NODES_PER_COLUMN (NODES_PER_COLUMN)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   function automatic int unsigned up_fiber(int unsigned x, int unsigned y);
      return y * ROW_STRIDE + CROSS_SPAN + x;
   endfunction

   function automatic int unsigned right_fiber(int unsigned x, int unsigned y);
      return y * ROW_STRIDE + 2 * x + 1;
   endfunction

   function automatic int unsigned out_fiber(int unsigned x, int unsigned y);
      return y * ROW_STRIDE + 2 * x;
   endfunction

   function automatic int unsigned left_of(int unsigned x, int unsigned y);
      return (x != 0) ? right_fiber(x - 1, y) : right_fiber(x, y);
   endfunction

   function automatic int unsigned right_of(int unsigned x, int unsigned y);
      return (x != LAST_X) ? right_fiber(x, y) : right_fiber(x - 1, y);
   endfunction

   function automatic int unsigned below(int unsigned x, int unsigned y);
      return (y != 0) ? up_fiber(x, y - 1) : up_fiber(x, y);
   endfunction

   function automatic int unsigned above(int unsigned x, int unsigned y);
      return (y != LAST_Y) ? up_fiber(x, y) : up_fiber(x, y - 1);
   endfunction

   function automatic rsp_payload_type predict_neighbor(logic [EDGE_W-1:0] edge_in,
                                                        logic [SLOT_W-1:0] slot_in);
      int unsigned     e;
      int unsigned     y;
      int unsigned     p;
      int unsigned     x;
      int unsigned     r;
      slot_code_type   slot;
      rsp_payload_type res;
      e    = 32'(edge_in);
      slot = slot_code_type'(slot_in);
      r    = 0;
      if (e >= FIBER_COUNT) begin
         res.neighbor_edge = '0;
         res.status        = STATUS_RANGE;
         return res;
      end
      y = e / ROW_STRIDE;
      p = e % ROW_STRIDE;
      if (p >= CROSS_SPAN) begin
         x = p - CROSS_SPAN;
         case (slot)
            SLOT_NEAR_LO:                    r = left_of(x, y);
            SLOT_NEAR_OUT_A, SLOT_NEAR_OUT_B: r = out_fiber(x, y);
            SLOT_NEAR_HI:                    r = right_of(x, y);
            SLOT_FAR_LO:                     r = left_of(x, y + 1);
            SLOT_FAR_OUT_A, SLOT_FAR_OUT_B:   r = out_fiber(x, y + 1);
            default:                         r = right_of(x, y + 1);
         endcase
      end else if (p % 2 != 0) begin
         x = p / 2;
         case (slot)
            SLOT_NEAR_LO:                    r = below(x, y);
            SLOT_NEAR_OUT_A, SLOT_NEAR_OUT_B: r = out_fiber(x, y);
            SLOT_NEAR_HI:                    r = above(x, y);
            SLOT_FAR_LO:                     r = below(x + 1, y);
            SLOT_FAR_OUT_A, SLOT_FAR_OUT_B:   r = out_fiber(x + 1, y);
            default:                         r = above(x + 1, y);
         endcase
      end else begin
         x = p / 2;
         case (pair_code_type'(slot_in[2:1]))
            PAIR_LEFT:  r = left_of(x, y);
            PAIR_RIGHT: r = right_of(x, y);
            PAIR_DOWN:  r = below(x, y);
            default:    r = above(x, y);
         endcase
      end
      res.neighbor_edge = r[EDGE_W-1:0];
      res.status        = STATUS_OK;
      return res;
   endfunction

   task automatic send_lookup(input logic [EDGE_W-1:0] edge_in,
                              input logic [SLOT_W-1:0] slot_in,
                              input rsp_payload_type   expected);
      while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= '{edge_index: edge_in, neighbor_slot: slot_in};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_neighbors = {pending_neighbors, expected};
   endtask

   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_neighbors.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("lattice_fiber_neighbor_top test failed");
      $finish;
   end

   // result side: random stalls, in-order compare
   initial begin
      rsp_payload_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_neighbors.size() == 0) begin
               $error("unexpected transaction: neighbor_edge %0d status %0d",
                      rsp_if.payload.neighbor_edge, rsp_if.payload.status);
               fail_count++;
            end else begin
               want = pending_neighbors.pop_front();
               if (rsp_if.payload.neighbor_edge !== want.neighbor_edge) begin
                  $error("neighbor_edge: expected %0d, actual %0d",
                         want.neighbor_edge, rsp_if.payload.neighbor_edge);
                  fail_count++;
               end
               if (rsp_if.payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_if.payload.status);
                  fail_count++;
               end
            end
         end
         rsp_if.ready <= !reset && (steady_run || $urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      int unsigned       idx;
      int unsigned       y;
      int unsigned       p;
      int unsigned       pick;
      logic [EDGE_W-1:0] e;
      logic [SLOT_W-1:0] s;
      rsp_payload_type   fixed_rsp;

      reset          <= 1'b1;
      steady_run     <= 1'b0;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (idx = 0; idx < DIRECTED_ROWS; idx++) begin
         e = directed_table[idx].edge_index;
         s = directed_table[idx].slot;
         if (directed_table[idx].fixed) begin
            fixed_rsp.neighbor_edge = directed_table[idx].fixed_edge;
            fixed_rsp.status        = directed_table[idx].fixed_status;
            send_lookup(e, s, fixed_rsp);
         end else begin
            send_lookup(e, s, predict_neighbor(e, s));
         end
      end
      wait_for_drain();

      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if (idx == RANDOM_ITEMS / 2) wait_for_drain();
         steady_run <= (idx >= 1000 && idx < 1300);
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            e = EDGE_W'($urandom_range(FIBER_COUNT, 32767));
         end else if (pick < 40) begin
            // rows and positions next to the lattice borders
            y = border_y[$urandom_range(0, 3)];
            p = border_p[$urandom_range(0, 8)];
            if (y == LAST_Y && p >= CROSS_SPAN) p = border_p[$urandom_range(0, 2)];
            e = EDGE_W'(y * ROW_STRIDE + p);
         end else begin
            e = EDGE_W'($urandom_range(0, FIBER_COUNT - 1));
         end
         s = SLOT_W'($urandom_range(0, 7));
         send_lookup(e, s, predict_neighbor(e, s));
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("lattice_fiber_neighbor_top test passed");
      end else begin
         $display("lattice_fiber_neighbor_top test failed");
      end
      $finish;
   end

endmodule
